[rtl/core/tpeb_pkg.sv]
// Shared types and constants for the priority event buffer.
// No dependencies; imported by tpeb_store and top_priority_event_buffer_top.
package tpeb_pkg;

  localparam int TIME_BITS   = 52;
  localparam int WEIGHT_BITS = 32;
  localparam int COUNT_BITS  = 32;
  localparam int HELD_W      = 6;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STOP  = 1'd1;

  // Item function codes
  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_READOUT = 1'b1;

  // Result kind codes
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic                          func;
    logic [TIME_BITS-1:0]          begin_time;
    logic [TIME_BITS-1:0]          end_time;
    logic signed [WEIGHT_BITS-1:0] weight;
  } tpeb_in_t;

  typedef struct packed {
    logic                          kind;
    logic                          accepted;
    logic [COUNT_BITS-1:0]         received_total;
    logic [HELD_W-1:0]             held_count;
    logic                          empty_res;
    logic [TIME_BITS-1:0]          out_begin;
    logic [TIME_BITS-1:0]          out_end;
    logic signed [WEIGHT_BITS-1:0] out_weight;
    logic                          last;
  } tpeb_out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]          ent_begin;
    logic [TIME_BITS-1:0]          ent_end;
    logic signed [WEIGHT_BITS-1:0] ent_weight;
  } tpeb_entry_t;

endpackage

[rtl/core/tpeb_store.sv]
// Event store: single write port, one registered read port.
// Depends on tpeb_pkg for the entry type.
module tpeb_store import tpeb_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tpeb_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output tpeb_entry_t   rdata
);

  tpeb_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/top_priority_event_buffer_top.sv]
// Top level of the bounded top-k priority event buffer.
// Depends on tpeb_pkg (types, codes) and tpeb_store (entry memory).
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------
//  input    | start, busy (take: start & !busy) | item (tpeb_in_t)
//  result   | res_strobe, one cycle    | res (tpeb_out_t)
//  config   | cfg_we                   | cfg_idx, cfg_data
//
// Sequence: an add that is rejected is acknowledged from ST_ADD; one stored without a sort
// is acknowledged from ST_APPEND. The stable insertion sort (ST_SORT, ST_LOAD, ST_CMP,
// ST_PLACE) takes each held entry past the first in turn and moves every lower-weight
// entry before it up one slot; ST_TRIM then cuts the store to MAX_KEPT.
// A readout then issues the first read in ST_RD_INIT and streams one entry per cycle.
// Reset (rst, synchronous) empties the store, clears the counter and opens the window
// fully. The receiver cannot stall: each result is on res for one cycle with res_strobe.
module top_priority_event_buffer_top import tpeb_pkg::*; #(
  parameter int MAX_KEPT = 16,
  parameter int SPARE    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tpeb_in_t             item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TIME_BITS-1:0] cfg_data,
  output logic                 res_strobe,
  output tpeb_out_t            res
);

  localparam int DEPTH = MAX_KEPT + SPARE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ADD     = 4'd1;
  localparam logic [3:0] ST_SORT    = 4'd2;
  localparam logic [3:0] ST_LOAD    = 4'd3;
  localparam logic [3:0] ST_CMP     = 4'd4;
  localparam logic [3:0] ST_PLACE   = 4'd5;
  localparam logic [3:0] ST_TRIM    = 4'd6;
  localparam logic [3:0] ST_APPEND  = 4'd7;
  localparam logic [3:0] ST_RD_INIT = 4'd8;
  localparam logic [3:0] ST_RD      = 4'd9;

  logic [3:0]            state;
  logic [TIME_BITS-1:0]  window_start;
  logic [TIME_BITS-1:0]  window_stop;
  logic [CNT_W-1:0]      held;
  logic [COUNT_BITS-1:0] received;
  tpeb_in_t              cur;      // item under work
  tpeb_entry_t           key;      // entry being inserted
  logic [CNT_W-1:0]      i_cnt;    // outer sort index
  logic [IDX_W-1:0]      j_idx;    // insertion slot
  logic [IDX_W-1:0]      r_idx;    // readout index

  // Memory port
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  tpeb_entry_t           mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  tpeb_entry_t           mem_rdata;

  logic [IDX_W-1:0]      i_idx;
  logic [CNT_W-1:0]      i_inc;
  logic [CNT_W-1:0]      held_inc;
  logic [CNT_W-1:0]      r_inc;
  logic                  in_window;
  logic                  move_up;
  tpeb_entry_t           cur_entry;

  assign busy      = (state != ST_IDLE);
  assign i_idx     = i_cnt[IDX_W-1:0];
  assign i_inc     = i_cnt + 1'b1;
  assign held_inc  = held + 1'b1;
  assign r_inc     = CNT_W'(r_idx) + 1'b1;
  // An event touching a window edge still counts as inside.
  assign in_window = !(cur.begin_time > window_stop || cur.end_time < window_start);
  // The shared comparator: shift the stored entry up while it ranks lower.
  assign move_up   = (mem_rdata.ent_weight < key.ent_weight);
  assign cur_entry = '{ent_begin: cur.begin_time, ent_end: cur.end_time,
                       ent_weight: cur.weight};

  tpeb_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Memory addressing for each sequencer step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = j_idx;
    mem_wdata = key;
    mem_raddr = '0;
    case (state)
      ST_SORT: begin
        mem_raddr = IDX_W'(1);
      end
      ST_LOAD: begin
        mem_raddr = i_idx - 1'b1;
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (move_up) begin
          mem_wdata = mem_rdata;
          mem_raddr = j_idx - IDX_W'(2);
        end else begin
          mem_raddr = i_idx + 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_raddr = i_idx + 1'b1;
      end
      ST_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = held[IDX_W-1:0];
        mem_wdata = cur_entry;
      end
      ST_RD: begin
        mem_raddr = r_idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_stop  <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WINDOW_START: window_start <= cfg_data;
        CFG_WINDOW_STOP:  window_stop  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= item;
    end
    if (state == ST_LOAD) begin
      key   <= mem_rdata;
      j_idx <= i_idx;
    end else if (state == ST_CMP && move_up) begin
      j_idx <= j_idx - 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held       <= '0;
      received   <= '0;
      i_cnt      <= '0;
      r_idx      <= '0;
      res_strobe <= 1'b0;
      res        <= '0;
    end else begin
      res_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (item.func == FUNC_ADD) begin
              // Count every add, saturating at the top.
              if (received != '1) begin
                received <= received + 1'b1;
              end
              state <= ST_ADD;
            end else begin
              state <= ST_SORT;
            end
          end
        end
        ST_ADD: begin
          if (!in_window) begin
            res_strobe <= 1'b1;
            res        <= '{kind: KIND_ACK, accepted: 1'b0, received_total: received,
                            held_count: HELD_W'(held), empty_res: 1'b0,
                            out_begin: '0, out_end: '0, out_weight: '0,
                            last: 1'b1};
            state      <= ST_IDLE;
          end else if (held == CNT_W'(DEPTH)) begin
            state <= ST_SORT;
          end else begin
            state <= ST_APPEND;
          end
        end
        ST_SORT: begin
          i_cnt <= CNT_W'(1);
          if (held > CNT_W'(1)) begin
            state <= ST_LOAD;
          end else begin
            state <= ST_TRIM;
          end
        end
        ST_LOAD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (move_up) begin
            // Slot zero is reached: drop the key there next.
            if (j_idx == IDX_W'(1)) begin
              state <= ST_PLACE;
            end
          end else begin
            i_cnt <= i_inc;
            state <= (i_inc < held) ? ST_LOAD : ST_TRIM;
          end
        end
        ST_PLACE: begin
          i_cnt <= i_inc;
          state <= (i_inc < held) ? ST_LOAD : ST_TRIM;
        end
        ST_TRIM: begin
          if (held > CNT_W'(MAX_KEPT)) begin
            held <= CNT_W'(MAX_KEPT);
          end
          state <= (cur.func == FUNC_READOUT) ? ST_RD_INIT : ST_APPEND;
        end
        ST_APPEND: begin
          held       <= held_inc;
          res_strobe <= 1'b1;
          res        <= '{kind: KIND_ACK, accepted: 1'b1, received_total: received,
                          held_count: HELD_W'(held_inc), empty_res: 1'b0,
                          out_begin: '0, out_end: '0, out_weight: '0,
                          last: 1'b1};
          state      <= ST_IDLE;
        end
        ST_RD_INIT: begin
          r_idx <= '0;
          if (held == '0) begin
            res_strobe <= 1'b1;
            res        <= '{kind: KIND_ENTRY, accepted: 1'b0, received_total: received,
                            held_count: '0, empty_res: 1'b1,
                            out_begin: '0, out_end: '0, out_weight: '0,
                            last: 1'b1};
            state      <= ST_IDLE;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          // Emit one kept entry per cycle; the next read is already issued.
          res_strobe <= 1'b1;
          res        <= '{kind: KIND_ENTRY, accepted: 1'b0, received_total: received,
                          held_count: HELD_W'(held), empty_res: 1'b0,
                          out_begin: mem_rdata.ent_begin, out_end: mem_rdata.ent_end,
                          out_weight: mem_rdata.ent_weight,
                          last: (r_inc == held)};
          r_idx      <= r_idx + 1'b1;
          if (r_inc == held) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/top_priority_event_buffer_top_test.sv]
// Self-checking testbench for the bounded top-k priority event buffer.
// Depends on tpeb_pkg (payload types, codes) and top_priority_event_buffer_top (the block).
// Predicts every ack and readout entry in-line; drives at negedge, samples at posedge.
module top_priority_event_buffer_top_test;
  import tpeb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEPT        = 16;
  localparam int SPARE           = 16;
  localparam int STORE_DEPTH     = MAX_KEPT + SPARE;
  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 100;
  // Idle cycles required before a window write.
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 40;
  // Allow for a full-store sort on every item, several times over.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int MAX_PRINTED     = 40;

  // One entry of the stimulus queue: either an item or a window register write.
  typedef struct {
    logic                 is_cfg;
    tpeb_in_t             payload;
    logic [CFG_IDX_W-1:0] idx;
    logic [TIME_BITS-1:0] data;
  } stim_op_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic                 busy;
  tpeb_in_t             item       = '0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [TIME_BITS-1:0] cfg_data   = '0;
  logic                 res_strobe;
  tpeb_out_t            res;

  // Stimulus and scoreboard.
  stim_op_t    pending_ops[$];
  tpeb_out_t   awaited_results[$];
  logic        took_item = 1'b0;
  int          error_count = 0;
  int unsigned result_index = 0;
  int unsigned cycle_count = 0;

  // Driver state.
  stim_op_t drive_op;
  logic     nxt_start;
  logic     nxt_we;
  int       quiet_cycles = 0;
  int       burst_left = 1;
  int       gap_left = 0;

  // Predicted buffer contents, window and add counter.
  tpeb_entry_t           kept [STORE_DEPTH];
  int                    kept_count;
  logic [COUNT_BITS-1:0] add_count;
  logic [TIME_BITS-1:0]  win_start;
  logic [TIME_BITS-1:0]  win_stop;
  tpeb_out_t             want;

  top_priority_event_buffer_top #(
    .MAX_KEPT (MAX_KEPT),
    .SPARE    (SPARE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .res_strobe (res_strobe),
    .res        (res)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Hold reset for a few cycles, then release it at a falling edge.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Guard against a hang: a missing result or a stuck busy ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** top_priority_event_buffer_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Stable insertion sort by descending weight, then drop everything past MAX_KEPT.
  function void rank_and_trim();
    tpeb_entry_t moving;
    int          j;
    for (int i = 1; i < kept_count; i++) begin
      moving = kept[i];
      j = i;
      // Strict compare: equal weights never pass each other, so arrival order holds.
      while (j > 0 && $signed(kept[j-1].ent_weight) < $signed(moving.ent_weight)) begin
        kept[j] = kept[j-1];
        j--;
      end
      kept[j] = moving;
    end
    if (kept_count > MAX_KEPT) kept_count = MAX_KEPT;
  endfunction

  // Advance the predicted state by one accepted item and queue the results it causes.
  function void project_results(tpeb_in_t it);
    tpeb_out_t r;
    logic      in_window;
    r = '0;
    if (it.func == FUNC_ADD) begin
      // Touching either window edge still counts as inside.
      in_window = !(it.begin_time > win_stop || it.end_time < win_start);
      // Saturate rather than wrap; 2^32 adds are out of reach here, so this only guards.
      if (add_count != '1) add_count = add_count + 1'b1;
      if (in_window) begin
        if (kept_count >= STORE_DEPTH) rank_and_trim();
        kept[kept_count] = '{it.begin_time, it.end_time, it.weight};
        kept_count++;
      end
      // Exactly one ack per add, stored or not.
      r.kind           = KIND_ACK;
      r.accepted       = in_window;
      r.received_total = add_count;
      r.held_count     = HELD_W'(kept_count);
      r.last           = 1'b1;
      awaited_results.push_back(r);
    end else begin
      rank_and_trim();
      r.kind           = KIND_ENTRY;
      r.received_total = add_count;
      r.held_count     = HELD_W'(kept_count);
      if (kept_count == 0) begin
        // Empty readout: a single zeroed entry flagged empty.
        r.empty_res = 1'b1;
        r.last      = 1'b1;
        awaited_results.push_back(r);
      end else begin
        for (int i = 0; i < kept_count; i++) begin
          r.out_begin  = kept[i].ent_begin;
          r.out_end    = kept[i].ent_end;
          r.out_weight = kept[i].ent_weight;
          r.last       = (i + 1 == kept_count);
          awaited_results.push_back(r);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string msg);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH @%0t result %0d: %s", $time, result_index, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) flag_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
  endtask

  // Sample at the rising edge: track window writes, score results, then predict new items.
  always @(posedge clk) begin
    if (rst) begin
      took_item  <= 1'b0;
      kept_count = 0;
      add_count  = '0;
      win_start  = '0;
      win_stop   = '1;
    end else begin
      took_item <= start && !busy;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW_START: win_start = cfg_data;
          CFG_WINDOW_STOP:  win_stop  = cfg_data;
          default: ;
        endcase
      end
      if (res_strobe) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, kind %0d", res.kind));
        end else begin
          want = awaited_results.pop_front();
          check_field("kind",           res.kind,           want.kind);
          check_field("accepted",       res.accepted,       want.accepted);
          check_field("received_total", res.received_total, want.received_total);
          check_field("held_count",     res.held_count,     want.held_count);
          check_field("empty_res",      res.empty_res,      want.empty_res);
          check_field("out_begin",      res.out_begin,      want.out_begin);
          check_field("out_end",        res.out_end,        want.out_end);
          check_field("out_weight",     res.out_weight,     want.out_weight);
          check_field("last",           res.last,           want.last);
        end
        result_index++;
      end
      if (start && !busy) project_results(item);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Change inputs at the falling edge. Items go out in bursts with random gaps;
  // a window write waits until every awaited result is in and the block has sat idle.
  always @(negedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      // Hold an item that busy kept out at the last edge.
      nxt_start = start && !took_item;
      nxt_we    = 1'b0;
      if (awaited_results.size() == 0 && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_start && pending_ops.size() != 0) begin
        if (pending_ops[0].is_cfg) begin
          if (quiet_cycles >= SETTLE_CYCLES) begin
            drive_op = pending_ops.pop_front();
            nxt_we   = 1'b1;
            cfg_idx  <= drive_op.idx;
            cfg_data <= drive_op.data;
            quiet_cycles = 0;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          drive_op  = pending_ops.pop_front();
          nxt_start = 1'b1;
          item      <= drive_op.payload;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Start a new burst; a zero gap joins it to the last one.
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [TIME_BITS-1:0] wide_rand();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // Pick a time that lands on, around or between the window edges often enough
  // to split adds between stored and rejected.
  function automatic logic [TIME_BITS-1:0] pick_time(logic [TIME_BITS-1:0] lo,
                                                       logic [TIME_BITS-1:0] hi);
    logic [63:0] span;
    logic [63:0] r64;
    span = 64'(hi) - 64'(lo) + 64'd1;
    r64  = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return lo + TIME_BITS'($urandom_range(0, 4)) - TIME_BITS'(2);
      4, 5:    return hi + TIME_BITS'($urandom_range(0, 4)) - TIME_BITS'(2);
      6, 7:    return (hi >= lo) ? lo + TIME_BITS'(r64 % span) : wide_rand();
      default: return wide_rand();
    endcase
  endfunction

  // Full-range weights half the time, with extremes and a small set of values to force ties.
  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:          return {1'b1, {(WEIGHT_BITS-1){1'b0}}};
      1:          return {1'b0, {(WEIGHT_BITS-1){1'b1}}};
      2, 3, 4:    return (WEIGHT_BITS'($urandom_range(0, 4)) - WEIGHT_BITS'(2)) << 16;
      default:    return $urandom;
    endcase
  endfunction

  task automatic push_add(logic [TIME_BITS-1:0] b, logic [TIME_BITS-1:0] e,
                          logic [WEIGHT_BITS-1:0] w);
    stim_op_t op;
    op = '{1'b0, '{FUNC_ADD, b, e, w}, '0, '0};
    pending_ops.push_back(op);
  endtask

  // Readout ignores the event fields; fill them anyway so every bit toggles.
  task automatic push_readout();
    stim_op_t op;
    op = '{1'b0, '{FUNC_READOUT, wide_rand(), wide_rand(), WEIGHT_BITS'($urandom)}, '0, '0};
    pending_ops.push_back(op);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [TIME_BITS-1:0] data);
    stim_op_t op;
    op = '{1'b1, '0, idx, data};
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [TIME_BITS-1:0] lo;
    logic [TIME_BITS-1:0] hi;
    int                   run;
    int                   count;

    // Directed part, first under the reset window (full span).
    push_readout();                                        // empty store
    push_add('0, '0, 32'h8000_0000);                       // lowest times, lowest weight
    push_add('1, '1, 32'h7fff_ffff);                       // highest times, highest weight
    push_add({13{4'h5}}, {13{4'ha}}, 32'h5555_5555);
    push_add({13{4'ha}}, {13{4'h5}}, 32'haaaa_aaaa);
    push_add(52'd10, 52'd11, 32'h0000_0000);               // three equal weights:
    push_add(52'd20, 52'd21, 32'h0000_0000);               // they must come out in
    push_add(52'd30, 52'd31, 32'h0000_0000);               // arrival order
    push_readout();
    push_readout();                                        // unchanged on a second pass

    // Narrow window to probe its edges.
    push_cfg(CFG_WINDOW_START, 52'd1000);
    push_cfg(CFG_WINDOW_STOP, 52'd2000);
    push_add(52'd2000, 52'd3000, 32'h0000_0001);           // begins on the stop edge: kept
    push_add(52'd2001, 52'd3000, 32'h0000_0002);           // begins past stop: dropped
    push_add(52'd0, 52'd1000, 32'h0000_0003);              // ends on the start edge: kept
    push_add(52'd0, 52'd999, 32'h0000_0004);               // ends before start: dropped
    push_add('0, '1, 32'hffff_0000);                       // spans the whole window
    push_add(52'd1500, 52'd1500, 32'h0001_0000);
    push_readout();

    // Random phases, each under its own window: runs of adds, mostly closed by a readout.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin                        // full span: every add is stored, store fills and trims
          lo = '0;
          hi = '1;
        end
        1: begin                        // inverted extremes: only a 0-to-max event survives
          lo = '1;
          hi = '0;
        end
        2: begin                        // narrow window
          lo = wide_rand();
          hi = lo + TIME_BITS'($urandom_range(0, 1 << 20));
        end
        3: begin
          lo = '0;
          hi = wide_rand();
        end
        default: begin
          lo = wide_rand();
          hi = wide_rand();
        end
      endcase
      push_cfg(CFG_WINDOW_START, lo);
      push_cfg(CFG_WINDOW_STOP, hi);
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        // Long runs overflow the spare room and force a sort and trim mid-stream.
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
        repeat (run) push_add(pick_time(lo, hi), pick_time(lo, hi), pick_weight());
        count += run;
        if ($urandom_range(0, 3) != 0) begin
          push_readout();
          count++;
        end
      end
      push_readout();
    end

    // Wait for the last item to go in, for every awaited result, then a quiet drain.
    @(negedge rst);
    while (pending_ops.size() != 0 || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** top_priority_event_buffer_top: PASSED **");
    end else begin
      $display("** top_priority_event_buffer_top: FAILED **");
    end
    $finish;
  end

endmodule
